// ===== rtl/core/sle_pkg.sv =====
`timescale 1ns / 1ps

package sle_pkg;

  // Default number of entries held in the cell row
  localparam int CAPACITY_DEF = 64;

  // Word field widths
  localparam int OP_W      = 3;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 6;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_UNIQUE = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SWEEP
  } cell_op_t;

  // Command broadcast from the sequencer to the cell row
  typedef struct packed {
    cell_op_t                  op;
    logic                      keep;
    logic signed [VAL_W-1:0]   val;
  } cell_cmd_t;

  // Outcome of one operation, handed to the output register
  typedef struct packed {
    logic signed [VAL_W-1:0]   value;
    logic [ST_W-1:0]           status;
  } seq_result_t;

endpackage

// ===== rtl/core/sle_cell.sv =====
`timescale 1ns / 1ps

module sle_cell #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF,
  parameter int IDX      = 0
) (
  input  logic                              clk,
  input  sle_pkg::cell_cmd_t                cmd,
  input  logic [$clog2(CAPACITY+1)-1:0]     count,
  input  logic [$clog2(CAPACITY)-1:0]       tail,
  input  logic signed [sle_pkg::VAL_W-1:0]  head,
  input  logic signed [sle_pkg::VAL_W-1:0]  left_v,
  input  logic signed [sle_pkg::VAL_W-1:0]  right_v,
  input  logic                              prev_lt,
  output logic signed [sle_pkg::VAL_W-1:0]  v,
  output logic                              lt
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  // Entry is live and strictly below the value being inserted
  assign lt = (CW'(IDX) < count) && (v < $signed(cmd.val));

  // Insert opens a slot by shifting right; sweep shifts left and appends at the tail
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CELL_INSERT: begin
        if (!lt) begin
          v <= prev_lt ? $signed(cmd.val) : left_v;
        end
      end
      CELL_SWEEP: begin
        v <= (cmd.keep && (tail == IW'(IDX))) ? head : right_v;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/sle_seq.sv =====
`timescale 1ns / 1ps

module sle_seq #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sle_pkg::OP_W-1:0]          in_op,
  input  logic signed [sle_pkg::VAL_W-1:0]  in_val,
  input  logic [sle_pkg::IDX_W-1:0]         in_idx,
  input  logic signed [sle_pkg::VAL_W-1:0]  head,
  output sle_pkg::cell_cmd_t                cmd,
  output logic [$clog2(CAPACITY+1)-1:0]     count,
  output logic [$clog2(CAPACITY)-1:0]       tail,
  input  logic                              out_free,
  output logic                              done,
  output sle_pkg::seq_result_t              res
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t                  state;
  logic [OP_W-1:0]         op_q;
  logic signed [VAL_W-1:0] val_q;
  logic [IDX_W-1:0]        idx_q;
  logic [CW-1:0]           k;
  logic [CW-1:0]           w;
  logic signed [VAL_W-1:0] last_kept;
  logic signed [VAL_W-1:0] res_val;
  logic [ST_W-1:0]         res_status;

  logic keep;
  logic hit;
  logic last_step;
  logic is_empty;
  logic is_full;
  logic out_of_range;
  logic idx_at_k;

  assign in_ready = (state == S_IDLE);
  assign done     = (state == S_DONE) && out_free;
  assign res      = '{value: res_val, status: res_status};

  assign is_empty     = (count == '0);
  assign is_full      = (count >= CW'(CAPACITY));
  assign out_of_range = (XW'(idx_q) >= XW'(count));
  assign idx_at_k     = (XW'(idx_q) == XW'(k));
  assign last_step    = ((k + CW'(1)) == count);

  // Decide whether the entry now at the head goes back into the row
  always_comb begin
    keep = 1'b1;
    hit  = 1'b0;
    unique case (op_q)
      OP_POP: begin
        keep = (k != '0);
        hit  = (k == '0);
      end
      OP_ERASE: begin
        keep = !idx_at_k;
        hit  = idx_at_k;
      end
      OP_READ: begin
        hit  = idx_at_k;
      end
      OP_REMOVE: begin
        keep = (head != val_q);
      end
      OP_UNIQUE: begin
        keep = (k == '0) || (head != last_kept);
      end
      default: begin
      end
    endcase
  end

  // Drive the cell row
  always_comb begin
    cmd.op   = CELL_HOLD;
    cmd.keep = keep;
    cmd.val  = val_q;
    if (state == S_CHECK && op_q == OP_INSERT && !is_full) begin
      cmd.op = CELL_INSERT;
    end else if (state == S_SWEEP) begin
      cmd.op = CELL_SWEEP;
    end
  end

  // Sequence one word: latch, check, sweep the row, hand off the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= in_op;
            val_q <= in_val;
            idx_q <= in_idx;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_val <= '0;
          k       <= '0;
          w       <= '0;
          tail    <= IW'(count - CW'(1));
          priority if (op_q == OP_INSERT) begin
            if (is_full) begin
              res_status <= ST_FULL;
            end else begin
              res_status <= ST_OK;
              count      <= count + CW'(1);
            end
            state <= S_DONE;
          end else if (op_q > OP_READ) begin
            res_status <= ST_OK;
            state      <= S_DONE;
          end else if (is_empty) begin
            res_status <= ST_EMPTY;
            state      <= S_DONE;
          end else if ((op_q == OP_ERASE || op_q == OP_READ) && out_of_range) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            res_status <= ST_OK;
            state      <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          k <= k + CW'(1);
          if (keep) begin
            w         <= w + CW'(1);
            last_kept <= head;
          end else begin
            tail <= tail - IW'(1);
          end
          if (hit) begin
            res_val <= head;
          end
          if (last_step) begin
            count <= keep ? (w + CW'(1)) : w;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/sorted_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Flow: insert, errors and unused codes go from the check state to the done state, which
//   loads m_tvalid; pop, erase, read, remove and unique first rotate the whole row once.
// Throughput: one word at a time, none taken until the last result enters the output
//   register; the rotation through the cell row moves one entry per cycle.
// Reset: synchronous; clears the entry count and control state, entries are left as is.

module sorted_list_engine_unit #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[2:0], value[34:3], index[40:35], zero pad [47:41]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_value[31:0], status[33:32], entry_count[40:34], zero pad [47:41]
  output logic [47:0] m_tdata
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PAD_W = 48 - VAL_W - ST_W - CNT_OUT_W;

  cell_cmd_t          cmd;
  logic [CW-1:0]      count;
  logic [IW-1:0]      tail;
  logic               done;
  logic               out_free;
  seq_result_t        res;
  logic signed [VAL_W-1:0] cv [CAPACITY];
  logic               lt [CAPACITY];

  assign out_free = !m_tvalid || m_tready;

  // Sequencer
  sle_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tdata[OP_W-1:0]),
    .in_val   ($signed(s_tdata[OP_W+VAL_W-1:OP_W])),
    .in_idx   (s_tdata[OP_W+VAL_W+IDX_W-1:OP_W+VAL_W]),
    .head     (cv[0]),
    .cmd      (cmd),
    .count    (count),
    .tail     (tail),
    .out_free (out_free),
    .done     (done),
    .res      (res)
  );

  // Row of cells, smallest entry in cell zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    logic                    prev_lt;

    if (i == 0) begin : g_first
      assign left_v  = cmd.val;
      assign prev_lt = 1'b1;
    end else begin : g_inner
      assign left_v  = cv[i-1];
      assign prev_lt = lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_body
      assign right_v = cv[i+1];
    end

    sle_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .count   (count),
      .tail    (tail),
      .head    (cv[0]),
      .left_v  (left_v),
      .right_v (right_v),
      .prev_lt (prev_lt),
      .v       (cv[i]),
      .lt      (lt[i])
    );
  end

  // Output register: load a finished word, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {PAD_W'(0), CNT_OUT_W'(count), res.status, res.value};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Entry count stays within the row
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // A result is only handed over when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    done |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending word");

  // The list does not change while waiting for a new word
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    s_tready |=> $stable(count))
    else $error("entry count changed while idle");

endmodule

// ===== sim/sorted_list_engine_unit_tb.sv =====
`timescale 1ns / 1ps

module sorted_list_engine_unit_tb;
  import sle_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int IDLE_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int LONG_HOLD  = 400;   // receiver hold-off for the pressure test
  localparam int DRAIN_WAIT = CAP + 16;

  // Operation codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam int VAL_MIN = 32'h8000_0000;
  localparam int VAL_MAX = 32'h7fff_ffff;

  typedef struct {
    int               value;
    logic [ST_W-1:0]  status;
    logic [6:0]       count;
  } list_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  // Shadow copy of the sorted list
  int shadow_entries [0:CAP-1];
  int shadow_count = 0;

  list_reply_t expected_replies[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  logic        long_hold_req = 1'b0;
  int          rx_hold_cnt = 0;

  sorted_list_engine_unit #(.CAPACITY(CAP)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Drop the entry at pos and close the gap
  task automatic shadow_drop(input int pos);
    for (int k = pos; k + 1 < shadow_count; k++) shadow_entries[k] = shadow_entries[k + 1];
    shadow_count--;
  endtask

  // Apply one operation to the shadow list and return the reply it should give
  task automatic predict_list_op(input logic [OP_W-1:0] op, input int val,
                                 input logic [IDX_W-1:0] idx, output list_reply_t reply);
    int pos;
    int wr;
    reply.value  = 0;
    reply.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= CAP) begin
          reply.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_entries[pos] < val) pos++;
          for (int k = shadow_count; k > pos; k--) shadow_entries[k] = shadow_entries[k - 1];
          shadow_entries[pos] = val;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.value = shadow_entries[0];
          shadow_drop(0);
        end
      end
      OP_ERASE, OP_READ: begin
        if (shadow_count == 0) begin
          reply.status = ST_EMPTY;
        end else if (int'(idx) >= shadow_count) begin
          reply.status = ST_RANGE;
        end else begin
          reply.value = shadow_entries[idx];
          if (op == OP_ERASE) shadow_drop(int'(idx));
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          wr = 0;
          for (int k = 0; k < shadow_count; k++) begin
            if (shadow_entries[k] != val) begin
              shadow_entries[wr] = shadow_entries[k];
              wr++;
            end
          end
          shadow_count = wr;
        end
      end
      OP_UNIQUE: begin
        if (shadow_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          wr = 1;
          for (int k = 1; k < shadow_count; k++) begin
            if (shadow_entries[k] != shadow_entries[wr - 1]) begin
              shadow_entries[wr] = shadow_entries[k];
              wr++;
            end
          end
          shadow_count = wr;
        end
      end
      default: ;
    endcase
    reply.count = shadow_count[6:0];
  endtask

  // Offer one word, wait for the handshake, then record what it should produce
  task automatic send_word(input logic [OP_W-1:0] op, input int val,
                           input logic [IDX_W-1:0] idx);
    list_reply_t reply;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, idx, val[VAL_W-1:0], op};
    do @(posedge clk); while (s_tready !== 1'b1);
    predict_list_op(op, val, idx, reply);
    expected_replies.push_back(reply);
  endtask

  // Mostly small values so that equal runs form, plus extremes and wide values
  function automatic int rand_value();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 8)) - 4;
      1: return int'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  // Mostly a valid position, sometimes anywhere in the field
  function automatic logic [IDX_W-1:0] rand_index();
    if (shadow_count > 0 && $urandom_range(0, 9) < 7)
      return IDX_W'($urandom_range(0, shadow_count - 1));
    return IDX_W'($urandom_range(0, 63));
  endfunction

  // Remove a value that is held most of the time
  function automatic int rand_victim();
    if (shadow_count > 0 && $urandom_range(0, 3) != 0)
      return shadow_entries[$urandom_range(0, shadow_count - 1)];
    return rand_value();
  endfunction

  task automatic test_empty_list();
    send_word(OP_POP, 0, '0);
    send_word(OP_ERASE, 0, '0);
    send_word(OP_READ, 0, 6'd63);
    send_word(OP_REMOVE, 7, '0);
    send_word(OP_UNIQUE, 0, '0);
    send_word(OP_SPARE_A, -1, 6'd63);
    send_word(OP_SPARE_B, VAL_MAX, '0);
  endtask

  task automatic test_extremes_and_ops();
    send_word(OP_INSERT, VAL_MAX, '0);
    send_word(OP_INSERT, VAL_MIN, '0);
    send_word(OP_INSERT, 0, '0);
    send_word(OP_INSERT, -1, '0);
    send_word(OP_INSERT, VAL_MIN, '0);
    send_word(OP_INSERT, VAL_MAX, '0);
    send_word(OP_READ, 0, '0);
    send_word(OP_READ, 0, 6'd5);
    send_word(OP_READ, 0, 6'd6);
    send_word(OP_ERASE, 0, 6'd63);
    send_word(OP_UNIQUE, 0, '0);
    send_word(OP_REMOVE, 12345, '0);
    send_word(OP_REMOVE, 0, '0);
    send_word(OP_ERASE, 0, 6'd2);
    send_word(OP_SPARE_A, 0, '0);
    send_word(OP_POP, 0, '0);
    send_word(OP_POP, 0, '0);
  endtask

  task automatic test_random_mix(input int n_words, input int insert_pct);
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 99) < insert_pct) begin
        send_word(OP_INSERT, rand_value(), rand_index());
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4:   send_word(OP_POP, rand_value(), rand_index());
          5, 6, 7, 8:      send_word(OP_ERASE, rand_value(), rand_index());
          9, 10, 11, 12, 13: send_word(OP_READ, rand_value(), rand_index());
          14, 15:          send_word(OP_REMOVE, rand_victim(), rand_index());
          16, 17:          send_word(OP_UNIQUE, rand_value(), rand_index());
          18:              send_word(OP_SPARE_A, rand_value(), rand_index());
          default:         send_word(OP_SPARE_B, rand_value(), rand_index());
        endcase
      end
    end
  endtask

  // Fill to capacity, overflow, compact, then drain past empty
  task automatic test_fill_and_drain();
    while (shadow_count < CAP) send_word(OP_INSERT, rand_value(), rand_index());
    repeat (3) send_word(OP_INSERT, rand_value(), rand_index());
    send_word(OP_READ, 0, 6'd63);
    send_word(OP_REMOVE, rand_victim(), '0);
    send_word(OP_UNIQUE, 0, '0);
    while (shadow_count > 0) begin
      if ($urandom_range(0, 1) == 0) send_word(OP_POP, 0, rand_index());
      else send_word(OP_ERASE, 0, rand_index());
    end
    send_word(OP_POP, 0, '0);
  endtask

  // Hold the receiver off while words keep coming so the input stalls
  task automatic test_output_backpressure();
    long_hold_req <= 1'b1;
    repeat (12) send_word(OP_INSERT, rand_value(), rand_index());
    repeat (4) send_word(OP_READ, 0, rand_index());
  endtask

  // Receiver ready: random hold bursts, plus a long hold on request
  always @(posedge clk) begin
    if (rx_hold_cnt > 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
      m_tready    <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      rx_hold_cnt   <= LONG_HOLD - 1;
      m_tready      <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_hold_cnt <= $urandom_range(0, 13);
      m_tready    <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    list_reply_t exp_reply;
    int          act_value;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      act_value = int'(m_tdata[31:0]);
      if (expected_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result word %h", $realtime, m_tdata);
      end else begin
        exp_reply = expected_replies.pop_front();
        if (act_value != exp_reply.value || m_tdata[33:32] !== exp_reply.status ||
            m_tdata[40:34] !== exp_reply.count || m_tdata[47:41] !== 7'b0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch value exp %0d act %0d, status exp %0d act %0d, count exp %0d act %0d, pad %h",
                     $realtime, exp_reply.value, act_value, exp_reply.status, m_tdata[33:32],
                     exp_reply.count, m_tdata[40:34], m_tdata[47:41]);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** sorted_list_engine_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_extremes_and_ops();

    for (int r = 0; r < 14; r++) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: test_random_mix(50, 30);
        1: test_random_mix(50, 50);
        2: test_random_mix(50, 70);
        default: test_random_mix(50, 90);
      endcase
      if (r == 4) test_fill_and_drain();
      if (r == 9) test_output_backpressure();
    end

    // Final stretch runs at full rate on both sides
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_mix(150, 55);
    s_tvalid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("** sorted_list_engine_unit: PASSED **");
    end else begin
      $display("** sorted_list_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
